>>> sv/assert_macros.svh
// Assertion macros used by the checker of this block.
// Each one samples on the rising edge of clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/ihex_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ihex_pkg;

	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_EOF   = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	localparam logic [2:0] CODE_NONE     = 3'd0;
	localparam logic [2:0] ERR_START     = 3'd0;
	localparam logic [2:0] ERR_SHORT     = 3'd1;
	localparam logic [2:0] ERR_HEX       = 3'd2;
	localparam logic [2:0] ERR_CHECKSUM  = 3'd3;
	localparam logic [2:0] ERR_LENGTH    = 3'd4;
	localparam logic [2:0] ERR_TYPE      = 3'd5;
	localparam logic [2:0] ERR_OVERLONG  = 3'd6;

	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] CHAR_COLON   = 8'h3A;
	localparam logic [3:0] MIN_CHARS    = 4'd11;
	localparam logic [7:0] REC_DATA     = 8'h00;
	localparam logic [7:0] REC_EOF      = 8'h01;
	localparam logic [8:0] HDR_BYTES    = 9'd5;
	localparam logic [8:0] DATA_OFFSET  = 9'd4;

	typedef enum logic [1:0] {
		VERDICT_ERROR,
		VERDICT_EOF,
		VERDICT_DATA
	} verdict_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ONE,
		ST_READ,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic in_ready;
		logic take_char;
		logic close_line;
		logic load_single;
		logic read_issue;
		logic load_byte;
	} ctrl_cmd_t;

	typedef struct packed {
		logic     in_valid;
		logic     halted;
		logic     close_req;
		logic     end_empty;
		verdict_t verdict;
		logic     len_zero;
		logic     last_byte;
		logic     slot_free;
	} dp_status_t;

endpackage
`default_nettype wire

>>> sv/ihex_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface ihex_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic       stream_end;

	modport source (output valid, output character, output stream_end, input ready);
	modport sink (input valid, input character, input stream_end, output ready);
endinterface

interface ihex_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [15:0] address;
	logic [7:0]  data_byte;
	logic [2:0]  error_code;
	logic        last;

	modport source (
		output valid, output kind, output address, output data_byte,
		output error_code, output last, input ready
	);
	modport sink (
		input valid, input kind, input address, input data_byte,
		input error_code, input last, output ready
	);
endinterface
`default_nettype wire

>>> sv/ihex_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module ihex_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

>>> sv/ihex_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module ihex_ctrl
	import ihex_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire dp_status_t status,
	output ctrl_cmd_t       cmd
);

	state_t state_q;
	state_t state_d;
	logic   accept;
	logic   live;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign accept = status.in_valid && (state_q == ST_IDLE);
	assign live   = accept && !status.halted;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (live && status.close_req && !status.end_empty) begin
					case (status.verdict)
						VERDICT_DATA: state_d = status.len_zero ? ST_IDLE : ST_READ;
						default:      state_d = ST_ONE;
					endcase
				end
			end
			ST_ONE: begin
				if (status.slot_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_READ: state_d = ST_EMIT;
			ST_EMIT: begin
				if (status.slot_free) begin
					state_d = status.last_byte ? ST_IDLE : ST_READ;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd             = '0;
		cmd.in_ready    = (state_q == ST_IDLE);
		cmd.take_char   = live && !status.close_req;
		cmd.close_line  = live && status.close_req && !status.end_empty;
		case (state_q)
			ST_ONE:  cmd.load_single = status.slot_free;
			ST_READ: cmd.read_issue  = 1'b1;
			ST_EMIT: cmd.load_byte   = status.slot_free;
			default: cmd.read_issue  = 1'b0;
		endcase
	end

endmodule
`default_nettype wire

>>> sv/ihex_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module ihex_datapath
	import ihex_pkg::*;
#(
	parameter int LINE_BYTES = 64,
	localparam int AW  = $clog2(LINE_BYTES),
	localparam int BCW = $clog2(LINE_BYTES + 1)
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic [7:0]  character,
	input  wire logic        stream_end,
	input  wire logic        out_ready,
	input  wire ctrl_cmd_t   cmd,
	output dp_status_t       status,
	output logic             out_valid,
	output logic [1:0]       out_kind,
	output logic [15:0]      out_address,
	output logic [7:0]       out_data_byte,
	output logic [2:0]       out_error_code,
	output logic             out_last
);

	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end
		return r;
	endfunction

	logic [3:0]     char_cnt_q;
	logic [BCW-1:0] byte_cnt_q;
	logic [3:0]     upper_q;
	logic           phase_q;
	logic [7:0]     sum_q;
	logic           start_ok_q;
	logic           hex_fault_q;
	logic           ovf_q;
	logic           halted_q;
	logic [7:0]     len_q;
	logic [15:0]    addr_q;
	logic [7:0]     type_q;
	logic [1:0]     pend_kind_q;
	logic [2:0]     pend_code_q;
	logic [7:0]     idx_q;
	logic           out_valid_q;
	logic [1:0]     out_kind_q;
	logic [15:0]    out_addr_q;
	logic [7:0]     out_data_q;
	logic [2:0]     out_code_q;
	logic           out_last_q;

	logic [4:0]     digit;
	logic [7:0]     new_byte;
	logic           ram_we;
	logic [AW-1:0]  ram_raddr;
	logic [8:0]     raddr_wide;
	logic [7:0]     ram_rdata;
	verdict_t       verdict;
	logic [2:0]     verdict_code;
	logic           is_last_byte;

	assign digit    = hex_digit(character);
	assign new_byte = {upper_q, digit[3:0]};
	assign ram_we   = cmd.take_char && (char_cnt_q != 4'd0) && phase_q
		&& (byte_cnt_q < BCW'(LINE_BYTES));
	assign raddr_wide = DATA_OFFSET + {1'b0, idx_q};
	assign ram_raddr  = raddr_wide[AW-1:0];
	assign is_last_byte = (idx_q == (len_q - 8'd1));

	always_comb begin
		verdict      = VERDICT_ERROR;
		verdict_code = ERR_START;
		if (char_cnt_q == 4'd0 || !start_ok_q) begin
			verdict_code = ERR_START;
		end else if (char_cnt_q < MIN_CHARS) begin
			verdict_code = ERR_SHORT;
		end else if (hex_fault_q || phase_q) begin
			verdict_code = ERR_HEX;
		end else if (ovf_q) begin
			verdict_code = ERR_OVERLONG;
		end else if (sum_q != 8'd0) begin
			verdict_code = ERR_CHECKSUM;
		end else if (type_q == REC_EOF) begin
			verdict      = VERDICT_EOF;
			verdict_code = CODE_NONE;
		end else if (type_q != REC_DATA) begin
			verdict_code = ERR_TYPE;
		end else if (9'(byte_cnt_q) < (HDR_BYTES + {1'b0, len_q})) begin
			verdict_code = ERR_LENGTH;
		end else begin
			verdict      = VERDICT_DATA;
			verdict_code = CODE_NONE;
		end
	end

	always_comb begin
		status.in_valid  = in_valid;
		status.halted    = halted_q;
		status.close_req = stream_end || (character == CHAR_NEWLINE);
		status.end_empty = stream_end && (char_cnt_q == 4'd0);
		status.verdict   = verdict;
		status.len_zero  = (len_q == 8'd0);
		status.last_byte = is_last_byte;
		status.slot_free = !out_valid_q || out_ready;
	end

	ihex_ram #(
		.WIDTH(8),
		.DEPTH(LINE_BYTES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (byte_cnt_q[AW-1:0]),
		.wdata (new_byte),
		.re    (cmd.read_issue),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_cnt_q  <= 4'd0;
			byte_cnt_q  <= '0;
			upper_q     <= 4'd0;
			phase_q     <= 1'b0;
			sum_q       <= 8'd0;
			start_ok_q  <= 1'b0;
			hex_fault_q <= 1'b0;
			ovf_q       <= 1'b0;
			halted_q    <= 1'b0;
		end else if (cmd.close_line) begin
			char_cnt_q  <= 4'd0;
			byte_cnt_q  <= '0;
			upper_q     <= 4'd0;
			phase_q     <= 1'b0;
			sum_q       <= 8'd0;
			start_ok_q  <= 1'b0;
			hex_fault_q <= 1'b0;
			ovf_q       <= 1'b0;
		end else if (cmd.take_char) begin
			if (char_cnt_q == 4'd0) begin
				start_ok_q <= (character == CHAR_COLON);
				char_cnt_q <= 4'd1;
			end else begin
				if (char_cnt_q < MIN_CHARS) begin
					char_cnt_q <= char_cnt_q + 4'd1;
				end
				if (!digit[4]) begin
					hex_fault_q <= 1'b1;
				end
				if (!phase_q) begin
					upper_q <= digit[3:0];
					phase_q <= 1'b1;
				end else begin
					phase_q <= 1'b0;
					sum_q   <= sum_q + new_byte;
					if (ram_we) begin
						byte_cnt_q <= byte_cnt_q + BCW'(1);
					end else begin
						ovf_q <= 1'b1;
					end
				end
			end
		end else if (cmd.load_single) begin
			halted_q <= 1'b1;
		end
	end

	// Capture the record header as it is decoded.
	always_ff @(posedge clk) begin
		if (ram_we) begin
			case (byte_cnt_q)
				BCW'(0): len_q          <= new_byte;
				BCW'(1): addr_q[15:8]   <= new_byte;
				BCW'(2): addr_q[7:0]    <= new_byte;
				BCW'(3): type_q         <= new_byte;
				default: type_q         <= type_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.close_line) begin
			pend_kind_q <= (verdict == VERDICT_EOF) ? KIND_EOF : KIND_ERROR;
			pend_code_q <= verdict_code;
			idx_q       <= 8'd0;
		end else if (cmd.load_byte) begin
			idx_q <= idx_q + 8'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_single || cmd.load_byte) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_single) begin
			out_kind_q <= pend_kind_q;
			out_addr_q <= (pend_kind_q == KIND_EOF) ? addr_q : 16'd0;
			out_data_q <= 8'd0;
			out_code_q <= pend_code_q;
			out_last_q <= 1'b1;
		end else if (cmd.load_byte) begin
			out_kind_q <= KIND_WRITE;
			out_addr_q <= addr_q + {8'd0, idx_q};
			out_data_q <= ram_rdata;
			out_code_q <= CODE_NONE;
			out_last_q <= is_last_byte;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_kind       = out_kind_q;
	assign out_address    = out_addr_q;
	assign out_data_byte  = out_data_q;
	assign out_error_code = out_code_q;
	assign out_last       = out_last_q;

endmodule
`default_nettype wire

>>> sv/intel_hex_record_loader_core.sv
// Intel HEX record loader.
// chars: one text character per transfer, or a stream_end flag that closes a
// pending line without a newline. results: flash byte writes, one end-of-file
// result, or one coded error result; last marks the final result of a line.
// A character that does not close a line is taken while the loader stays
// ready. A closing character is followed by one load of the output register
// for an error or end-of-file result, or, per data byte, by one line-store
// read and then one load of the output register. The line store is a RAM with
// one write and one registered read port; its read sets the per-byte cost.
// The output register lets the next character be taken while the last result
// of a line still waits; a stalled receiver holds the loader in its emit
// states and then keeps chars.ready low.
// After end-of-file or an error every character is taken and dropped.
// Reset clears the line state and the halt flag; the line store needs no
// clearing, as only entries written in the current line are read.
`timescale 1ns / 1ps
`default_nettype none
module intel_hex_record_loader_core
	import ihex_pkg::*;
#(
	parameter int LINE_BYTES = 64
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	ihex_char_if.sink      chars,
	ihex_result_if.source  results
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	ihex_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.cmd    (cmd)
	);

	ihex_datapath #(
		.LINE_BYTES(LINE_BYTES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (chars.valid),
		.character      (chars.character),
		.stream_end     (chars.stream_end),
		.out_ready      (results.ready),
		.cmd            (cmd),
		.status         (status),
		.out_valid      (results.valid),
		.out_kind       (results.kind),
		.out_address    (results.address),
		.out_data_byte  (results.data_byte),
		.out_error_code (results.error_code),
		.out_last       (results.last)
	);

	assign chars.ready = cmd.in_ready;

endmodule
`default_nettype wire

>>> sv/ihex_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module ihex_checker
	import ihex_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        res_valid,
	input wire logic        res_ready,
	input wire logic [1:0]  kind,
	input wire logic [15:0] address,
	input wire logic [7:0]  data_byte,
	input wire logic [2:0]  error_code,
	input wire logic        last
);

	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else if (res_valid && res_ready && kind != KIND_WRITE) begin
			done_q <= 1'b1;
		end
	end

	`ASSERT_NEXT(a_stall_hold, res_valid && !res_ready, res_valid && $stable({kind, address, data_byte, error_code, last}), "result changed while stalled")
	`ASSERT_SAME(a_halt_quiet, done_q, !res_valid, "result after end-of-file or error")
	`ASSERT_SAME(a_final_last, res_valid && (kind == KIND_EOF || kind == KIND_ERROR), last, "terminal result without last")
	`ASSERT_SAME(a_error_clean, res_valid && kind == KIND_ERROR, address == 16'd0 && data_byte == 8'd0 && error_code <= ERR_OVERLONG, "malformed error result")
	`ASSERT_SAME(a_kind_known, res_valid, kind == KIND_WRITE || kind == KIND_EOF || kind == KIND_ERROR, "unknown result kind")

endmodule

bind intel_hex_record_loader_core ihex_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (results.valid),
	.res_ready  (results.ready),
	.kind       (results.kind),
	.address    (results.address),
	.data_byte  (results.data_byte),
	.error_code (results.error_code),
	.last       (results.last)
);
`default_nettype wire
